// ===== rtl/ogbd_pkg.sv =====
// Shared types and constants for the occupancy grid block downsampler.
`default_nettype none

package ogbd_pkg;

    localparam int MAX_GRID_COLS  = 256;
    localparam int MAX_IMAGE_SIDE = 4096;
    localparam int BLOCK_SIDE_MAX = 64;

    localparam int COL_W    = $clog2(MAX_GRID_COLS);      // cell column index
    localparam int ROW_W    = 12;                         // cell row output
    localparam int SIDE_W   = $clog2(MAX_IMAGE_SIDE) + 1; // image side 1..4096
    localparam int BLK_W    = $clog2(BLOCK_SIDE_MAX) + 1; // block side 1..64
    localparam int OFS_W    = $clog2(BLOCK_SIDE_MAX);     // offset inside block
    localparam int PIX_W    = 8;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH     = 2'd0,
        REG_IMAGE_HEIGHT    = 2'd1,
        REG_PIXELS_PER_CELL = 2'd2,
        REG_OBSTACLE_VALUE  = 2'd3
    } cfg_reg_t;

    // Where the current pixel falls in the grid.
    typedef struct packed {
        logic             kept;       // pixel lies in a full, stored block
        logic             first;      // top-left pixel of its block
        logic             last_px;    // bottom-right pixel of its block
        logic             last_cell;  // block is the final cell of the grid
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } pix_info_t;

endpackage

`default_nettype wire

// ===== rtl/ogbd_raster.sv =====
// Raster position tracker: pixel, block offset and grid cell of the next pixel.
`default_nettype none

module ogbd_raster
    import ogbd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              restart,
    input  wire logic              step,
    input  wire logic [SIDE_W-1:0] width,
    input  wire logic [SIDE_W-1:0] height,
    input  wire logic [BLK_W-1:0]  side,
    output pix_info_t              info
);

    logic [SIDE_W-1:0] px_reg, px_next;
    logic [SIDE_W-1:0] py_reg, py_next;
    logic [OFS_W-1:0]  ox_reg, ox_next;
    logic [OFS_W-1:0]  oy_reg, oy_next;
    logic [COL_W:0]    col_reg, col_next;    // saturates at MAX_GRID_COLS
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SIDE_W-1:0] bx_reg, bx_next;      // x of the current block's left edge
    logic [SIDE_W-1:0] by_reg, by_next;      // y of the current block's top edge

    logic [BLK_W-1:0]  ox_inc, oy_inc;
    logic [SIDE_W-1:0] px_inc, py_inc;
    logic              ox_wrap, oy_wrap, row_end, frame_end;
    logic [SIDE_W:0]   bx_end, by_end, bx_end2, by_end2;

    assign ox_inc    = {1'b0, ox_reg} + BLK_W'(1);
    assign oy_inc    = {1'b0, oy_reg} + BLK_W'(1);
    assign px_inc    = px_reg + SIDE_W'(1);
    assign py_inc    = py_reg + SIDE_W'(1);
    assign ox_wrap   = ox_inc >= side;
    assign oy_wrap   = oy_inc >= side;
    assign row_end   = px_inc >= width;
    assign frame_end = py_inc >= height;

    // block fits when its far edge stays inside the image
    assign bx_end  = {1'b0, bx_reg} + (SIDE_W+1)'(side);
    assign by_end  = {1'b0, by_reg} + (SIDE_W+1)'(side);
    assign bx_end2 = bx_end + (SIDE_W+1)'(side);
    assign by_end2 = by_end + (SIDE_W+1)'(side);

    always_comb
    begin
        info.kept      = !col_reg[COL_W]
                         && (bx_end <= {1'b0, width}) && (by_end <= {1'b0, height});
        info.first     = (ox_reg == '0) && (oy_reg == '0);
        info.last_px   = (ox_inc == side) && (oy_inc == side);
        info.last_cell = (by_end2 > {1'b0, height})
                         && ((col_reg[COL_W-1:0] == COL_W'(MAX_GRID_COLS - 1))
                             || (bx_end2 > {1'b0, width}));
        info.col       = col_reg[COL_W-1:0];
        info.row       = row_reg;
    end

    always_comb
    begin
        px_next  = px_reg;
        py_next  = py_reg;
        ox_next  = ox_reg;
        oy_next  = oy_reg;
        col_next = col_reg;
        row_next = row_reg;
        bx_next  = bx_reg;
        by_next  = by_reg;
        if (restart)
        begin
            px_next  = '0;
            py_next  = '0;
            ox_next  = '0;
            oy_next  = '0;
            col_next = '0;
            row_next = '0;
            bx_next  = '0;
            by_next  = '0;
        end
        else if (step)
        begin
            if (row_end)
            begin
                px_next  = '0;
                ox_next  = '0;
                col_next = '0;
                bx_next  = '0;
                if (frame_end)
                begin
                    py_next  = '0;
                    oy_next  = '0;
                    row_next = '0;
                    by_next  = '0;
                end
                else
                begin
                    py_next = py_inc;
                    if (oy_wrap)
                    begin
                        oy_next  = '0;
                        row_next = row_reg + ROW_W'(1);
                        by_next  = by_reg + SIDE_W'(side);
                    end
                    else
                    begin
                        oy_next = oy_inc[OFS_W-1:0];
                    end
                end
            end
            else
            begin
                px_next = px_inc;
                if (ox_wrap)
                begin
                    ox_next = '0;
                    bx_next = bx_reg + SIDE_W'(side);
                    if (!col_reg[COL_W])
                    begin
                        col_next = col_reg + (COL_W+1)'(1);
                    end
                end
                else
                begin
                    ox_next = ox_inc[OFS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            px_reg  <= '0;
            py_reg  <= '0;
            ox_reg  <= '0;
            oy_reg  <= '0;
            col_reg <= '0;
            row_reg <= '0;
            bx_reg  <= '0;
            by_reg  <= '0;
        end
        else
        begin
            px_reg  <= px_next;
            py_reg  <= py_next;
            ox_reg  <= ox_next;
            oy_reg  <= oy_next;
            col_reg <= col_next;
            row_reg <= row_next;
            bx_reg  <= bx_next;
            by_reg  <= by_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/occupancy_grid_block_downsampler.sv =====
// Top level: pools image pixel blocks into occupancy grid cells.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-----------------------------------------
//  pixel   | pixel_valid | pixel_stall | pixel_value
//  cell    | cell_valid  | cell_stall  | cell_row, cell_col, blocked, last_cell
//  config  | cfg_we      | -           | cfg_index, cfg_data
//
//  One pixel per cycle while pixel_stall is low. A pixel reads its column's flag
//  from the 256x1 flag RAM on the accept edge and stage 1 writes the merged flag
//  back; a back-to-back write to the same column is forwarded around the RAM.
//  A cell beat is registered when stage 1 writes back its bottom-right pixel.
//  pixel_stall rises only while a cell is waiting in the output register,
//  the cell_stall is high and the pixel in flight finishes another cell.
//  Reset restores the default geometry; the flag RAM needs no clearing.
`default_nettype none

module occupancy_grid_block_downsampler
    import ogbd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 pixel_valid,
    output logic                      pixel_stall,
    input  wire logic [PIX_W-1:0]     pixel_value,
    output logic                      cell_valid,
    input  wire logic                 cell_stall,
    output logic [ROW_W-1:0]          cell_row,
    output logic [COL_W-1:0]          cell_col,
    output logic                      blocked,
    output logic                      last_cell
);

    logic [SIDE_W-1:0] width_reg, height_reg;
    logic [BLK_W-1:0]  side_reg;
    logic [PIX_W-1:0]  obstacle_reg;

    pix_info_t info;
    logic      adv, accept;

    // stage 1: flag read in flight
    logic             s1_valid_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_first_reg, s1_emit_reg, s1_hit_reg, s1_last_reg;

    logic             flag_mem [MAX_GRID_COLS];
    logic             rd_reg;
    logic             fwd_valid_reg;
    logic [COL_W-1:0] fwd_col_reg;
    logic             fwd_data_reg;
    logic             old_flag, new_flag, wr_en;

    logic             out_valid_reg;

    // config: sizes are clamped on write, the obstacle value takes the low bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= SIDE_W'(640);
            height_reg   <= SIDE_W'(480);
            side_reg     <= BLK_W'(4);
            obstacle_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:
                begin
                    if (cfg_data == '0)
                        width_reg <= SIDE_W'(1);
                    else if (cfg_data > CFG_W'(MAX_IMAGE_SIDE))
                        width_reg <= SIDE_W'(MAX_IMAGE_SIDE);
                    else
                        width_reg <= cfg_data[SIDE_W-1:0];
                end
                REG_IMAGE_HEIGHT:
                begin
                    if (cfg_data == '0)
                        height_reg <= SIDE_W'(1);
                    else if (cfg_data > CFG_W'(MAX_IMAGE_SIDE))
                        height_reg <= SIDE_W'(MAX_IMAGE_SIDE);
                    else
                        height_reg <= cfg_data[SIDE_W-1:0];
                end
                REG_PIXELS_PER_CELL:
                begin
                    if (cfg_data[BLK_W-1:0] == '0)
                        side_reg <= BLK_W'(1);
                    else if (cfg_data[BLK_W-1:0] > BLK_W'(BLOCK_SIDE_MAX))
                        side_reg <= BLK_W'(BLOCK_SIDE_MAX);
                    else
                        side_reg <= cfg_data[BLK_W-1:0];
                end
                REG_OBSTACLE_VALUE:
                begin
                    obstacle_reg <= cfg_data[PIX_W-1:0];
                end
                default:
                begin
                    obstacle_reg <= obstacle_reg;
                end
            endcase
        end
    end

    assign adv         = !(s1_valid_reg && s1_emit_reg && out_valid_reg && cell_stall);
    assign pixel_stall = !adv;
    assign accept      = pixel_valid && adv;

    ogbd_raster u_raster (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_we),
        .step    (accept),
        .width   (width_reg),
        .height  (height_reg),
        .side    (side_reg),
        .info    (info)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= accept && info.kept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg   <= info.col;
            s1_row_reg   <= info.row;
            s1_first_reg <= info.first;
            s1_emit_reg  <= info.last_px;
            s1_last_reg  <= info.last_cell;
            s1_hit_reg   <= (pixel_value == obstacle_reg);
        end
    end

    // read-modify-write of the column flag
    assign old_flag = (fwd_valid_reg && (fwd_col_reg == s1_col_reg)) ? fwd_data_reg : rd_reg;
    assign new_flag = s1_first_reg ? s1_hit_reg : (old_flag || s1_hit_reg);
    assign wr_en    = s1_valid_reg && adv;

    always_ff @(posedge clk)
    begin
        if (accept)
            rd_reg <= flag_mem[info.col];
        if (wr_en)
            flag_mem[s1_col_reg] <= new_flag;
    end

    // the write landing on the read edge is not seen by the RAM read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fwd_valid_reg <= 1'b0;
        else if (wr_en)
            fwd_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            fwd_col_reg  <= s1_col_reg;
            fwd_data_reg <= new_flag;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (wr_en && s1_emit_reg)
            out_valid_reg <= 1'b1;
        else if (!cell_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && s1_emit_reg)
        begin
            cell_row  <= s1_row_reg;
            cell_col  <= s1_col_reg;
            blocked   <= new_flag;
            last_cell <= s1_last_reg;
        end
    end

    assign cell_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== sim/occupancy_grid_block_downsampler_tb.sv =====
// Self-checking testbench for the occupancy grid block downsampler.
`default_nettype none

module occupancy_grid_block_downsampler_tb;
    import ogbd_pkg::*;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             blocked;
        logic             is_last;
    } cell_t;

    // Tracks raster position and per-column obstacle flags, predicts cells.
    class cell_scoreboard;
        logic [CFG_W-1:0] width_reg;
        logic [CFG_W-1:0] height_reg;
        logic [BLK_W-1:0] side_reg;
        logic [PIX_W-1:0] obstacle_reg;
        int               px_x, px_y, ofs_x, ofs_y, col_idx, row_idx;
        bit               obstacle_seen [MAX_GRID_COLS];
        cell_t            pending_cells [$];
        int               errors;
        int               cells_checked;
        int               pixels_seen;

        function new();
            width_reg    = 13'd640;
            height_reg   = 13'd480;
            side_reg     = 7'd4;
            obstacle_reg = 8'd0;
            foreach (obstacle_seen[i])
                obstacle_seen[i] = 1'b0;
            errors        = 0;
            cells_checked = 0;
            pixels_seen   = 0;
            restart();
        endfunction

        function void restart();
            px_x    = 0;
            px_y    = 0;
            ofs_x   = 0;
            ofs_y   = 0;
            col_idx = 0;
            row_idx = 0;
        endfunction

        function void apply_reg(cfg_reg_t idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_IMAGE_WIDTH:     width_reg    = data;
                REG_IMAGE_HEIGHT:    height_reg   = data;
                REG_PIXELS_PER_CELL: side_reg     = data[BLK_W-1:0];
                REG_OBSTACLE_VALUE:  obstacle_reg = data[PIX_W-1:0];
                default:             return;
            endcase
            restart();
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix);
            int    w, h, p, kept, grid_h;
            bit    hit;
            cell_t c;
            w = (width_reg == 0) ? 1 :
                ((width_reg > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : int'(width_reg));
            h = (height_reg == 0) ? 1 :
                ((height_reg > MAX_IMAGE_SIDE) ? MAX_IMAGE_SIDE : int'(height_reg));
            p = (side_reg == 0) ? 1 :
                ((side_reg > BLOCK_SIDE_MAX) ? BLOCK_SIDE_MAX : int'(side_reg));
            kept   = (w / p < MAX_GRID_COLS) ? w / p : MAX_GRID_COLS;
            grid_h = h / p;
            pixels_seen++;

            if (col_idx < kept && row_idx < grid_h) begin
                hit = (pix == obstacle_reg);
                // top-left pixel opens the block, the rest accumulate
                if (ofs_x == 0 && ofs_y == 0)
                    obstacle_seen[col_idx] = hit;
                else
                    obstacle_seen[col_idx] = obstacle_seen[col_idx] | hit;
                if (ofs_x == p - 1 && ofs_y == p - 1) begin
                    c.row     = ROW_W'(row_idx);
                    c.col     = COL_W'(col_idx);
                    c.blocked = obstacle_seen[col_idx];
                    c.is_last = (row_idx == grid_h - 1) && (col_idx == kept - 1);
                    pending_cells.insert(pending_cells.size(), c);
                end
            end

            px_x++;
            ofs_x++;
            if (ofs_x >= p) begin
                ofs_x = 0;
                if (col_idx < MAX_GRID_COLS)
                    col_idx++;
            end
            if (px_x >= w) begin
                px_x    = 0;
                ofs_x   = 0;
                col_idx = 0;
                px_y++;
                ofs_y++;
                if (ofs_y >= p) begin
                    ofs_y = 0;
                    row_idx++;
                end
                if (px_y >= h) begin
                    px_y    = 0;
                    ofs_y   = 0;
                    row_idx = 0;
                end
            end
        endfunction

        function void check_cell(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                 logic blk, logic is_last);
            cell_t exp_cell;
            if (pending_cells.size() == 0) begin
                $error("cell beat with nothing pending: row %0d col %0d", row, col);
                errors++;
                return;
            end
            exp_cell = pending_cells.pop_front();
            cells_checked++;
            if (row !== exp_cell.row) begin
                $error("cell_row: expected %0d, got %0d", exp_cell.row, row);
                errors++;
            end
            if (col !== exp_cell.col) begin
                $error("cell_col: expected %0d, got %0d", exp_cell.col, col);
                errors++;
            end
            if (blk !== exp_cell.blocked) begin
                $error("blocked: expected %0d, got %0d", exp_cell.blocked, blk);
                errors++;
            end
            if (is_last !== exp_cell.is_last) begin
                $error("last_cell: expected %0d, got %0d", exp_cell.is_last, is_last);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending_cells.size();
        endfunction
    endclass

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             cfg_we      = 1'b0;
    cfg_reg_t         cfg_index   = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0] cfg_data    = '0;
    logic             pixel_valid = 1'b0;
    logic [PIX_W-1:0] pixel_value = '0;
    logic             cell_stall  = 1'b0;
    logic             pixel_stall;
    logic             cell_valid;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
    logic             blocked;
    logic             last_cell;

    cell_scoreboard sb;
    bit             calm       = 1'b0;
    int             geometries = 1;

    occupancy_grid_block_downsampler i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_value (pixel_value),
        .cell_valid  (cell_valid),
        .cell_stall  (cell_stall),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .blocked     (blocked),
        .last_cell   (last_cell)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // cell side: check accepted beats, stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
            cell_stall <= 1'b0;
        else
        begin
            if (cell_valid === 1'b1 && !cell_stall)
                sb.check_cell(cell_row, cell_col, blocked, last_cell);
            cell_stall <= !calm && ($urandom_range(0, 99) < 38);
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] value);
        pixel_valid <= 1'b1;
        pixel_value <= value;
        do
            @(posedge clk);
        while (pixel_stall !== 1'b0);
        sb.note_pixel(value);
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 38)
            begin
                pixel_valid <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    // drop valid and let every pending cell come out before touching config
    task automatic finish_stream();
        pixel_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic stream(input int n, input int density);
        logic [PIX_W-1:0] value;
        for (int i = 0; i < n; i++)
        begin
            // density is obstacle odds per ten thousand beats
            if ($urandom_range(0, 9999) < density)
                value = sb.obstacle_reg;
            else
                value = sb.obstacle_reg ^ PIX_W'($urandom_range(1, 255));
            send_pixel(value);
        end
        finish_stream();
    endtask

    task automatic program_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.apply_reg(idx, data);
    endtask

    task automatic set_geometry(input int w, input int h, input int p, input int obst);
        logic [CFG_W-1:0] side_word;
        logic [CFG_W-1:0] obst_word;
        // junk in the unused upper bits must be ignored
        side_word                 = CFG_W'($urandom);
        side_word[BLK_W-1:0]      = BLK_W'(p);
        obst_word                 = CFG_W'($urandom);
        obst_word[PIX_W-1:0]      = PIX_W'(obst);
        program_reg(REG_IMAGE_WIDTH, CFG_W'(w));
        program_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
        program_reg(REG_PIXELS_PER_CELL, side_word);
        program_reg(REG_OBSTACLE_VALUE, obst_word);
        cfg_we <= 1'b0;
        geometries++;
    endtask

    initial
    begin
        logic [PIX_W-1:0] quad_image [16];
        logic [PIX_W-1:0] tiny_image [5];
        int               random_pixels;
        int               w, h, p, n;

        quad_image = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6,
                       8'd255, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd128};
        tiny_image = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd1};
        random_pixels = 0;
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry: 640 wide, 4x4 blocks, obstacle 0; no cell row finishes
        stream(40, 500);

        // 16 wide rows, block side and obstacle value keep their reset values
        program_reg(REG_IMAGE_WIDTH, CFG_W'(16));
        cfg_we <= 1'b0;
        geometries++;
        stream(128, 1500);

        // 4x4 image, 2x2 blocks, obstacle 255 in the two left cells
        set_geometry(4, 4, 2, 255);
        foreach (quad_image[i])
            send_pixel(quad_image[i]);
        finish_stream();

        // one pixel per cell, last beat wraps into a new image
        set_geometry(2, 2, 1, 0);
        foreach (tiny_image[i])
            send_pixel(tiny_image[i]);
        finish_stream();

        // zero width acts as one, oversized height; no idling here
        calm = 1'b1;
        set_geometry(0, 8191, 1, $urandom_range(0, 255));
        stream(200, 5000);
        calm = 1'b0;

        // dropped columns over two rows, then a wrap into a new image
        set_geometry(258, 2, 1, $urandom_range(0, 255));
        stream(520, 4000);

        // block side 0 acts as 1
        set_geometry(3, 3, 0, $urandom_range(0, 255));
        stream(18, 3000);

        // blocks bigger than the image in one direction, first across, then down
        set_geometry(5, 7, 6, $urandom_range(0, 255));
        stream(40, 3000);
        set_geometry(10, 5, 6, $urandom_range(0, 255));
        stream(30, 3000);

        while (random_pixels < 150)
        begin
            w = $urandom_range(1, 24);
            h = $urandom_range(1, 24);
            if ($urandom_range(0, 9) < 7)
                p = $urandom_range(1, 4);
            else if ($urandom_range(0, 2) != 0)
                p = $urandom_range(5, 8);
            else
                p = $urandom_range(0, 127);
            n = $urandom_range(w * h / 2 + 1, 2 * w * h + 3);
            if (n > 60)
                n = 60;
            set_geometry(w, h, p, $urandom_range(0, 255));
            stream(n, $urandom_range(0, 3000));
            random_pixels += n;
        end

        repeat (10) @(posedge clk);
        if (sb.outstanding() != 0)
        begin
            $error("%0d cells never arrived", sb.outstanding());
            sb.errors++;
        end

        $display("Ran %0d pixel beats and checked %0d cell beats over %0d geometries,",
                 sb.pixels_seen, sb.cells_checked, geometries);
        $display("with out-of-range sides and block sizes, dropped columns and empty grids.");
        if (sb.errors == 0)
            $display("occupancy_grid_block_downsampler: match");
        else
            $display("occupancy_grid_block_downsampler: mismatch");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("occupancy_grid_block_downsampler: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
